// ===== hdl/bqe_pkg.sv =====
package bqe_pkg;

  localparam int NUM_BANDS    = 18;
  localparam int NUM_FILTERS  = NUM_BANDS + 3;
  localparam int NUM_CHANNELS = 2;
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 32;
  localparam int STATE_W      = 40;
  localparam int GUARD        = 8;
  localparam int COEF_FRAC    = COEF_W - 5;
  localparam int PROD_SHIFT   = COEF_FRAC - GUARD;
  localparam int COEF_DEPTH   = 128;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int ROWS         = NUM_CHANNELS * NUM_FILTERS;
  localparam int ROW_AW       = $clog2(ROWS);
  localparam int FILT_W       = $clog2(NUM_FILTERS + 1);
  localparam int GAIN_W       = 16;
  localparam int GAIN_SHIFT   = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int MUL_A_W      = COEF_W + 1;
  localparam int MUL_P_W      = MUL_A_W + SAMPLE_W;
  localparam int ACC_W        = STATE_W + 4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN    = 3'd0,
    REG_POST_GAIN   = 3'd1,
    REG_EQ_ENABLE   = 3'd2,
    REG_BASS_ENABLE = 3'd3,
    REG_BASS_MODE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                        command;
    logic                        channel;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        frame_end;
    logic [COEF_AW-1:0]          coef_address;
    logic signed [COEF_W-1:0]    coef_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // saturate to the sample width, msb of the result is the clip flag
  function automatic logic [SAMPLE_W:0] sat_smp(input logic signed [MUL_P_W-1:0] v);
    logic signed [MUL_P_W-1:0] hi;
    logic signed [MUL_P_W-1:0] lo;
    hi = (MUL_P_W'(1) <<< (SAMPLE_W - 1)) - MUL_P_W'(1);
    lo = ~hi;
    if (v > hi) begin
      sat_smp = {1'b1, hi[SAMPLE_W-1:0]};
    end else if (v < lo) begin
      sat_smp = {1'b1, lo[SAMPLE_W-1:0]};
    end else begin
      sat_smp = {1'b0, v[SAMPLE_W-1:0]};
    end
  endfunction

  function automatic logic [STATE_W:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
    lo = ~hi;
    if (v > hi) begin
      sat_st = {1'b1, hi[STATE_W-1:0]};
    end else if (v < lo) begin
      sat_st = {1'b1, lo[STATE_W-1:0]};
    end else begin
      sat_st = {1'b0, v[STATE_W-1:0]};
    end
  endfunction

endpackage

// ===== hdl/bqe_in_if.sv =====
interface bqe_in_if import bqe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       frame_end;
  logic [COEF_AW-1:0]         coef_address;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, command, channel, sample_in, frame_end, coef_address,
                  coef_value, input ready);
  modport sink (input valid, command, channel, sample_in, frame_end, coef_address,
                coef_value, output ready);
endinterface

// ===== hdl/bqe_out_if.sv =====
interface bqe_out_if import bqe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       frame_end_out;
  logic                       clipped;

  modport source (output valid, channel_out, sample_out, frame_end_out, clipped,
                  input ready);
  modport sink (input valid, channel_out, sample_out, frame_end_out, clipped,
                output ready);
endinterface

// ===== hdl/bqe_cfg_if.sv =====
interface bqe_cfg_if import bqe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bqe_ram.sv =====
module bqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/bqe_front.sv =====
module bqe_front import bqe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bqe_in_if.sink   din,
  output q_head_t  q_head,
  input  logic     q_pop
);
  item_t      slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  item_t      item_new;

  assign din.ready = (count != 2'd2);
  assign push      = din.valid && din.ready;

  always_comb begin
    item_new.command      = din.command;
    item_new.channel      = din.channel;
    item_new.sample       = din.sample_in;
    item_new.frame_end    = din.frame_end;
    item_new.coef_address = din.coef_address;
    item_new.coef_value   = din.coef_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= item_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  assign q_head.valid = (count != 2'd0);
  assign q_head.item  = slot[rptr];
endmodule

// ===== hdl/bqe_back.sv =====
module bqe_back import bqe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bqe_cfg_if.sink  cfg,
  bqe_out_if.source dout,
  input  q_head_t  q_head,
  output logic     q_pop
);
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PRE    = 9'b000000010,
    ST_PRE_R  = 9'b000000100,
    ST_BQ     = 9'b000001000,
    ST_SQ     = 9'b000010000,
    ST_SQ_R   = 9'b000100000,
    ST_MIX    = 9'b001000000,
    ST_POST   = 9'b010000000,
    ST_POST_R = 9'b100000000
  } state_t;

  localparam logic [2:0] BQ_LAST = 3'd6;
  localparam logic signed [MUL_P_W-1:0] HALF_C = MUL_P_W'(1) <<< (PROD_SHIFT - 1);
  localparam logic signed [MUL_P_W-1:0] HALF_G = MUL_P_W'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [MUL_P_W-1:0] HALF_S = MUL_P_W'(1) <<< (SAMPLE_W - 2);
  localparam logic signed [ACC_W-1:0]   HALF_Y = ACC_W'(1) <<< (GUARD - 1);

  state_t state;

  logic [GAIN_W-1:0] pre_gain;
  logic [GAIN_W-1:0] post_gain;
  logic              eq_en;
  logic              bass_en;
  logic              bass_mode;

  logic                       chan;
  logic                       frame;
  logic                       clip;
  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] bx;
  logic signed [SAMPLE_W-1:0] y;
  logic [FILT_W-1:0]          filt;
  logic [2:0]                 bq_cnt;
  logic signed [MUL_P_W-1:0]  mul_q;
  logic signed [STATE_W-1:0]  z1q;
  logic signed [STATE_W-1:0]  z2q;
  logic signed [ACC_W-1:0]    acc1;
  logic signed [ACC_W-1:0]    acc2;
  logic [ROWS-1:0]            row_valid;

  logic                       res_valid;
  logic                       res_chan;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_frame;
  logic                       res_clip;

  // coefficient and delay memories
  logic                   coef_we;
  logic [COEF_AW-1:0]     coef_raddr;
  logic [COEF_W-1:0]      coef_rdata;
  logic                   coef_re;
  logic                   dly_we;
  logic                   dly_re;
  logic [ROW_AW-1:0]      row;
  logic [2*STATE_W-1:0]   dly_rdata;
  logic [2*STATE_W-1:0]   dly_wdata;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic                       mul_en;

  logic signed [MUL_P_W-1:0] rnd_c;
  logic signed [MUL_P_W-1:0] rnd_g;
  logic signed [MUL_P_W-1:0] rnd_s;
  logic signed [ACC_W-1:0]   rc;
  logic signed [ACC_W-1:0]   acc0;
  logic signed [ACC_W-1:0]   ysum;
  logic [SAMPLE_W:0]         y_sat;
  logic [SAMPLE_W:0]         g_sat;
  logic [SAMPLE_W:0]         s_sat;
  logic [SAMPLE_W:0]         m_sat;
  logic [STATE_W:0]          n1_sat;
  logic [STATE_W:0]          n2_sat;
  logic signed [SAMPLE_W-1:0] d_mag;
  logic                      out_free;

  assign cfg.ready = 1'b1;
  assign q_pop     = (state == ST_IDLE) && q_head.valid;
  assign coef_we   = q_pop && (q_head.item.command == CMD_LOAD);
  assign out_free  = !res_valid || dout.ready;

  assign coef_re    = (state == ST_BQ) && (bq_cnt < 3'd5);
  assign coef_raddr = (COEF_AW'(filt) << 2) + COEF_AW'(filt) + COEF_AW'(bq_cnt);
  assign row        = ((NUM_CHANNELS > 1) && chan) ? ROW_AW'(NUM_FILTERS) + ROW_AW'(filt)
                                                   : ROW_AW'(filt);
  assign dly_re     = (state == ST_BQ) && (bq_cnt == 3'd0);
  assign dly_we     = (state == ST_BQ) && (bq_cnt == BQ_LAST);
  assign dly_wdata  = {n1_sat[STATE_W-1:0], n2_sat[STATE_W-1:0]};

  bqe_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (q_head.item.coef_address),
    .wdata (q_head.item.coef_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bqe_ram #(.WIDTH(2 * STATE_W), .DEPTH(ROWS)) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (row),
    .wdata (dly_wdata),
    .re    (dly_re),
    .raddr (row),
    .rdata (dly_rdata)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a  = MUL_A_W'($signed(coef_rdata));
    mul_b  = bx;
    mul_en = 1'b0;
    unique case (state)
      ST_PRE: begin
        mul_a  = $signed({1'b0, pre_gain});
        mul_b  = x_in;
        mul_en = 1'b1;
      end
      ST_POST: begin
        mul_a  = $signed({1'b0, post_gain});
        mul_b  = x;
        mul_en = 1'b1;
      end
      ST_SQ: begin
        mul_a  = MUL_A_W'(y);
        mul_b  = y;
        mul_en = 1'b1;
      end
      ST_BQ: begin
        mul_b  = (bq_cnt >= 3'd4) ? y : bx;
        mul_en = (bq_cnt != 3'd0) && (bq_cnt != BQ_LAST);
      end
      ST_IDLE, ST_PRE_R, ST_SQ_R, ST_MIX, ST_POST_R: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  always_comb begin
    rnd_c  = (mul_q + HALF_C) >>> PROD_SHIFT;
    rnd_g  = (mul_q + HALF_G) >>> GAIN_SHIFT;
    rnd_s  = (mul_q + HALF_S) >>> (SAMPLE_W - 1);
    rc     = $signed(rnd_c[ACC_W-1:0]);
    acc0   = rc + ACC_W'(z1q);
    ysum   = (acc0 + HALF_Y) >>> GUARD;
    y_sat  = sat_smp(MUL_P_W'(ysum));
    g_sat  = sat_smp(rnd_g);
    s_sat  = sat_smp(rnd_s);
    m_sat  = sat_smp(MUL_P_W'(x) + (MUL_P_W'(y) >>> 1));
    n1_sat = sat_st(acc1);
    n2_sat = sat_st(acc2 - rc);
    d_mag  = $signed(s_sat[SAMPLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_gain  <= GAIN_W'(4096);
      post_gain <= GAIN_W'(4096);
      eq_en     <= 1'b0;
      bass_en   <= 1'b0;
      bass_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PRE_GAIN:    pre_gain  <= cfg.data;
        REG_POST_GAIN:   post_gain <= cfg.data;
        REG_EQ_ENABLE:   eq_en     <= cfg.data[0];
        REG_BASS_ENABLE: bass_en   <= cfg.data[0];
        REG_BASS_MODE:   bass_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (dly_we) begin
      row_valid[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      bq_cnt    <= 3'd0;
      filt      <= '0;
      clip      <= 1'b0;
    end else begin
      // the post step reloads the result register itself
      if (res_valid && dout.ready && (state != ST_POST_R)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && (q_head.item.command == CMD_SAMPLE)) begin
            chan  <= q_head.item.channel;
            frame <= q_head.item.frame_end;
            x_in  <= q_head.item.sample;
            clip  <= 1'b0;
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          state <= ST_PRE_R;
        end
        ST_PRE_R: begin
          x      <= $signed(g_sat[SAMPLE_W-1:0]);
          bx     <= $signed(g_sat[SAMPLE_W-1:0]);
          clip   <= clip | g_sat[SAMPLE_W];
          bq_cnt <= 3'd0;
          if (eq_en) begin
            filt  <= '0;
            state <= ST_BQ;
          end else if (bass_en) begin
            filt  <= bass_mode ? FILT_W'(NUM_BANDS + 1) : FILT_W'(NUM_BANDS);
            state <= ST_BQ;
          end else begin
            state <= ST_POST;
          end
        end
        ST_BQ: begin
          bq_cnt <= (bq_cnt == BQ_LAST) ? 3'd0 : bq_cnt + 3'd1;
          unique case (bq_cnt)
            3'd1: begin
              z1q <= row_valid[row] ? $signed(dly_rdata[2*STATE_W-1:STATE_W]) : '0;
              z2q <= row_valid[row] ? $signed(dly_rdata[STATE_W-1:0]) : '0;
            end
            3'd2: begin
              y    <= $signed(y_sat[SAMPLE_W-1:0]);
              clip <= clip | y_sat[SAMPLE_W];
            end
            3'd3: acc1 <= ACC_W'(z2q) + rc;
            3'd4: acc2 <= rc;
            3'd5: acc1 <= acc1 - rc;
            3'd6: begin
              clip   <= clip | n1_sat[STATE_W] | n2_sat[STATE_W];
              bx     <= y;
              if (filt <= FILT_W'(NUM_BANDS)) begin
                x <= y;
              end
              // walk the bands, then pick the bass stage
              if (filt < FILT_W'(NUM_BANDS - 1)) begin
                filt <= filt + FILT_W'(1);
              end else if (filt == FILT_W'(NUM_BANDS - 1)) begin
                if (bass_en) begin
                  filt <= bass_mode ? FILT_W'(NUM_BANDS + 1) : FILT_W'(NUM_BANDS);
                end else begin
                  state <= ST_POST;
                end
              end else if (filt == FILT_W'(NUM_BANDS)) begin
                state <= ST_POST;
              end else if (filt == FILT_W'(NUM_BANDS + 1)) begin
                state <= ST_SQ;
              end else begin
                state <= ST_MIX;
              end
            end
            default: ;
          endcase
        end
        ST_SQ: begin
          state <= ST_SQ_R;
        end
        ST_SQ_R: begin
          bx     <= y[SAMPLE_W-1] ? -d_mag : d_mag;
          clip   <= clip | s_sat[SAMPLE_W];
          filt   <= FILT_W'(NUM_BANDS + 2);
          bq_cnt <= 3'd0;
          state  <= ST_BQ;
        end
        ST_MIX: begin
          x     <= $signed(m_sat[SAMPLE_W-1:0]);
          clip  <= clip | m_sat[SAMPLE_W];
          state <= ST_POST;
        end
        ST_POST: begin
          state <= ST_POST_R;
        end
        ST_POST_R: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_chan   <= chan;
            res_sample <= $signed(g_sat[SAMPLE_W-1:0]);
            res_frame  <= frame;
            res_clip   <= clip | g_sat[SAMPLE_W];
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign dout.valid         = res_valid;
  assign dout.channel_out   = res_chan;
  assign dout.sample_out    = res_sample;
  assign dout.frame_end_out = res_frame;
  assign dout.clipped       = res_clip;

`ifndef SYNTH
  a_res_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_POST_R))
    else $error("result raised outside post gain step");
  a_filt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BQ) |-> (filt < FILT_W'(NUM_FILTERS)))
    else $error("filter index out of range");
  a_clip_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRE) |-> !clip)
    else $error("clip flag not cleared for new sample");
  a_bq_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BQ && bq_cnt == BQ_LAST) |=> (bq_cnt == 3'd0))
    else $error("biquad step counter did not wrap");
`endif
endmodule

// ===== hdl/biquad_eq_bass_chain_top.sv =====
// channel | role   | moves
// din     | sink   | sample or coefficient load request
// dout    | source | processed sample
// cfg     | sink   | register write (pre_gain, post_gain, eq_enable, bass_enable, bass_mode)
//
// a coefficient load is written when the idle engine takes it; a sample runs pre gain, the
// enabled biquads (18 bands plus the bass filter) and post gain; the harmonic enhancer runs two bass
// biquads and adds the square and the mix steps
// one shared 33x24 multiplier and one coefficient memory read port serve all steps
// rst is synchronous: registers to reset values, delay rows read as zero until written
// a two entry queue lets din take up to two requests while the engine works or dout stalls
module biquad_eq_bass_chain_top import bqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bqe_in_if.sink    din,
  bqe_out_if.source dout,
  bqe_cfg_if.sink   cfg
);
  q_head_t q_head;
  logic    q_pop;

  bqe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  bqe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .dout   (dout),
    .q_head (q_head),
    .q_pop  (q_pop)
  );
endmodule
